/* rtl/core/tsc_pkg.sv */
// Shared types, codes and reset constants for the touch swipe classifier.
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int POS_W          = 12;
    localparam int TICK_W         = 32;
    localparam int OFF_W          = 16;
    localparam int FAST_W         = 16;
    localparam int THR_W          = 8;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int IN_TDATA_W     = 64;
    localparam int OUT_TDATA_W    = 40;

    localparam logic [FAST_W-1:0] FAST_TIME_RESET = 16'd300;
    localparam logic [THR_W-1:0]  MOVE_THR_RESET  = 8'd5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FAST_TIME = 1'd0,
        REG_MOVE_THR  = 1'd1
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_MOVE    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        LOCK_NONE  = 2'd0,
        LOCK_HORIZ = 2'd1,
        LOCK_DOWN  = 2'd2,
        LOCK_UP    = 2'd3
    } t_lock;

    typedef enum logic [1:0] {
        SIGN_RIGHT   = 2'd0,
        SIGN_LEFT    = 2'd1,
        SIGN_UNKNOWN = 2'd2
    } t_sign;

    typedef enum logic [1:0] {
        KIND_MOVE = 2'd0,
        KIND_FAST = 2'd1,
        KIND_SLOW = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    typedef struct packed {
        t_lock lock;
        t_sign sign;
    } t_ctrl;

    typedef struct packed {
        logic [OFF_W-1:0] off_y;
        logic [OFF_W-1:0] off_x;
        t_dir             dir;
        t_kind            kind;
    } t_result;

endpackage

/* rtl/core/tsc_step.sv */
// Combinational update of the gesture state and result for one touch item.
`timescale 1ns / 1ps

module tsc_step
    import tsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [1:0]            i_op,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [TICK_W-1:0]     i_tick,
    input  logic [COORD_BITS-1:0] i_last_x,
    input  logic [COORD_BITS-1:0] i_last_y,
    input  logic [TICK_W-1:0]     i_press_tick,
    input  logic [OFF_W-1:0]      i_acc_x,
    input  logic [OFF_W-1:0]      i_acc_y,
    input  t_ctrl                 i_ctrl,
    input  logic [FAST_W-1:0]     i_fast_time,
    input  logic [THR_W-1:0]      i_move_thr,
    output logic [COORD_BITS-1:0] o_last_x,
    output logic [COORD_BITS-1:0] o_last_y,
    output logic [TICK_W-1:0]     o_press_tick,
    output logic [OFF_W-1:0]      o_acc_x,
    output logic [OFF_W-1:0]      o_acc_y,
    output t_ctrl                 o_ctrl,
    output logic                  o_has_result,
    output t_result               o_result
);

    logic [15:0]                w_px16;
    logic [15:0]                w_py16;
    logic [COORD_BITS-1:0]      w_px;
    logic [COORD_BITS-1:0]      w_py;
    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [COORD_BITS:0]        w_mag_dx;
    logic [COORD_BITS:0]        w_mag_dy;
    logic [COORD_BITS:0]        w_thr;
    logic signed [OFF_W-1:0]    w_dx16;
    logic signed [OFF_W-1:0]    w_dy16;
    logic [TICK_W-1:0]          w_elapsed;
    logic                       w_fast;
    t_op                        w_op;

    assign w_px16   = {4'b0, i_pos_x};
    assign w_py16   = {4'b0, i_pos_y};
    assign w_px     = w_px16[COORD_BITS-1:0];
    assign w_py     = w_py16[COORD_BITS-1:0];
    assign w_dx     = $signed({1'b0, w_px}) - $signed({1'b0, i_last_x});
    assign w_dy     = $signed({1'b0, w_py}) - $signed({1'b0, i_last_y});
    assign w_mag_dx = w_dx[COORD_BITS] ? (COORD_BITS+1)'(-w_dx) : (COORD_BITS+1)'(w_dx);
    assign w_mag_dy = w_dy[COORD_BITS] ? (COORD_BITS+1)'(-w_dy) : (COORD_BITS+1)'(w_dy);
    assign w_thr    = (COORD_BITS+1)'(i_move_thr);
    assign w_dx16   = OFF_W'(w_dx);
    assign w_dy16   = OFF_W'(w_dy);
    assign w_elapsed = i_tick - i_press_tick;
    assign w_fast    = w_elapsed < TICK_W'(i_fast_time);
    assign w_op      = t_op'(i_op);

    always_comb begin
        o_last_x        = i_last_x;
        o_last_y        = i_last_y;
        o_press_tick    = i_press_tick;
        o_acc_x         = i_acc_x;
        o_acc_y         = i_acc_y;
        o_ctrl          = i_ctrl;
        o_has_result    = 1'b0;
        o_result.kind   = KIND_MOVE;
        o_result.dir    = DIR_RIGHT;
        o_result.off_x  = '0;
        o_result.off_y  = '0;
        unique case (w_op) inside
            OP_PRESS: begin
                o_last_x     = w_px;
                o_last_y     = w_py;
                o_press_tick = i_tick;
                o_acc_x      = '0;
                o_acc_y      = '0;
                o_ctrl.lock  = LOCK_NONE;
                o_ctrl.sign  = SIGN_UNKNOWN;
            end
            OP_MOVE, OP_RELEASE: begin
                o_last_x = w_px;
                o_last_y = w_py;
                o_acc_x  = i_acc_x + w_dx16;
                o_acc_y  = i_acc_y + w_dy16;
                if (w_dx > 0) begin
                    o_ctrl.sign = SIGN_RIGHT;
                end else if (w_dx < 0) begin
                    o_ctrl.sign = SIGN_LEFT;
                end
                if (w_op == OP_MOVE && i_ctrl.lock == LOCK_NONE) begin
                    if (w_mag_dx > w_mag_dy && w_mag_dx > w_thr) begin
                        o_ctrl.lock = LOCK_HORIZ;
                    end else if (w_mag_dy > w_mag_dx && w_mag_dy > w_thr) begin
                        o_ctrl.lock = w_dy[COORD_BITS] ? LOCK_UP : LOCK_DOWN;
                    end
                end
                o_has_result   = o_ctrl.lock != LOCK_NONE;
                o_result.off_x = o_acc_x;
                o_result.off_y = o_acc_y;
                if (w_op == OP_MOVE) begin
                    o_result.kind = KIND_MOVE;
                end else begin
                    o_result.kind = w_fast ? KIND_FAST : KIND_SLOW;
                end
                case (o_ctrl.lock)
                    LOCK_HORIZ: o_result.dir = (o_ctrl.sign == SIGN_RIGHT) ? DIR_RIGHT
                                                                            : DIR_LEFT;
                    LOCK_DOWN:  o_result.dir = DIR_DOWN;
                    default:    o_result.dir = DIR_UP;
                endcase
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/touch_swipe_classifier_unit.sv */
// Top level of the touch swipe classifier: stream ports, config registers, pipeline.
// Pipeline: 2 register stages, the input register and then the result register.
// Throughput: one item per cycle unless a result stalls and the held item gives one;
// each register holds one item, so input is taken while a result waits downstream.
// Press and unused op codes give no result and never stall.
// Reset (synchronous, active low): config to 300 and 5, gesture state cleared,
// both stages emptied.
`timescale 1ns / 1ps

module touch_swipe_classifier_unit
    import tsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // op[1:0], pos_x[13:2], pos_y[25:14], tick[57:26], zero pad[63:58]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // msg_kind[1:0], direction[3:2], disp_x[19:4], disp_y[35:20], zero pad[39:36]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic [FAST_W-1:0]     r_fast_time;
    logic [THR_W-1:0]      r_move_thr;

    logic                  r_in_valid;
    logic [1:0]            r_in_op;
    logic [POS_W-1:0]      r_in_pos_x;
    logic [POS_W-1:0]      r_in_pos_y;
    logic [TICK_W-1:0]     r_in_tick;

    logic [COORD_BITS-1:0] r_last_x;
    logic [COORD_BITS-1:0] r_last_y;
    logic [TICK_W-1:0]     r_press_tick;
    logic [OFF_W-1:0]      r_acc_x;
    logic [OFF_W-1:0]      r_acc_y;
    t_ctrl                 r_ctrl;

    logic [COORD_BITS-1:0] n_last_x;
    logic [COORD_BITS-1:0] n_last_y;
    logic [TICK_W-1:0]     n_press_tick;
    logic [OFF_W-1:0]      n_acc_x;
    logic [OFF_W-1:0]      n_acc_y;
    t_ctrl                 n_ctrl;
    logic                  n_has_result;
    t_result               n_result;

    logic                  r_out_valid;
    t_result               r_out;

    logic                  w_out_free;
    logic                  w_advance;
    logic                  w_in_take;

    tsc_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_op         (r_in_op),
        .i_pos_x      (r_in_pos_x),
        .i_pos_y      (r_in_pos_y),
        .i_tick       (r_in_tick),
        .i_last_x     (r_last_x),
        .i_last_y     (r_last_y),
        .i_press_tick (r_press_tick),
        .i_acc_x      (r_acc_x),
        .i_acc_y      (r_acc_y),
        .i_ctrl       (r_ctrl),
        .i_fast_time  (r_fast_time),
        .i_move_thr   (r_move_thr),
        .o_last_x     (n_last_x),
        .o_last_y     (n_last_y),
        .o_press_tick (n_press_tick),
        .o_acc_x      (n_acc_x),
        .o_acc_y      (n_acc_y),
        .o_ctrl       (n_ctrl),
        .o_has_result (n_has_result),
        .o_result     (n_result)
    );

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_advance       = r_in_valid && (w_out_free || !n_has_result);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out.off_y, r_out.off_x, r_out.dir, r_out.kind};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_time <= FAST_TIME_RESET;
            r_move_thr  <= MOVE_THR_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_FAST_TIME: r_fast_time <= i_cfg_wdata;
                REG_MOVE_THR:  r_move_thr  <= i_cfg_wdata[THR_W-1:0];
                default:       r_fast_time <= r_fast_time;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op    <= i_s_axis_tdata[1:0];
            r_in_pos_x <= i_s_axis_tdata[13:2];
            r_in_pos_y <= i_s_axis_tdata[25:14];
            r_in_tick  <= i_s_axis_tdata[57:26];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_press_tick <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_ctrl.lock  <= LOCK_NONE;
            r_ctrl.sign  <= SIGN_UNKNOWN;
        end else if (w_advance) begin
            r_last_x     <= n_last_x;
            r_last_y     <= n_last_y;
            r_press_tick <= n_press_tick;
            r_acc_x      <= n_acc_x;
            r_acc_y      <= n_acc_y;
            r_ctrl       <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && n_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_advance && n_has_result) begin
            r_out <= n_result;
        end
    end

endmodule

/* rtl/core/tsc_checker.sv */
// Port-level assertions for the touch swipe classifier, bound to the top level.
`timescale 1ns / 1ps

module tsc_checker
    import tsc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result item changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] == KIND_MOVE
                          || o_m_axis_tdata[1:0] == KIND_FAST
                          || o_m_axis_tdata[1:0] == KIND_SLOW))
        else $error("result item carries an unused kind");

    a_rise_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 2))
        else $error("result appeared without an item accepted two cycles before");

    a_press_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata[1:0] == OP_PRESS
        |-> ##2 !$rose(o_m_axis_tvalid))
        else $error("press item produced a result");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[OUT_TDATA_W-1:36] == '0)
        else $error("result padding not zero");

endmodule

bind touch_swipe_classifier_unit tsc_checker u_tsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/sv/touch_swipe_classifier_unit_tb.sv */
// Self-checking testbench for the touch swipe classifier: directed script, random gestures.
`timescale 1ns / 1ps

module touch_swipe_classifier_unit_tb;
    import tsc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int COORD_MAX = 4095;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_FIXED
    } t_chk;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] px;
        logic [11:0] py;
        logic [31:0] tk;
        t_chk        chk;
        t_result     res;
    } t_script_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // op[1:0], pos_x[13:2], pos_y[25:14], tick[57:26], zero pad[63:58]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // msg_kind[1:0], direction[3:2], disp_x[19:4], disp_y[35:20], zero pad[39:36]
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    touch_swipe_classifier_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // gesture tracker state and register copies
    logic [FAST_W-1:0] fast_ticks = FAST_TIME_RESET;
    logic [THR_W-1:0]  move_thr   = MOVE_THR_RESET;
    logic [11:0]       last_x     = '0;
    logic [11:0]       last_y     = '0;
    logic [31:0]       press_tick = '0;
    t_lock             lock       = LOCK_NONE;
    t_sign             sign       = SIGN_UNKNOWN;
    logic [OFF_W-1:0]  acc_x      = '0;
    logic [OFF_W-1:0]  acc_y      = '0;

    t_result pending_swipes[$];

    int mismatches  = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_moves     = 0;
    int n_fast      = 0;
    int n_slow      = 0;
    int n_settings  = 1;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    t_script_row swipe_script [25] = '{
        '{OP_MOVE,    12'd10,   12'd0,    32'd0,         CHK_FIXED,
          '{16'd0, 16'd10, DIR_RIGHT, KIND_MOVE}},
        '{OP_UNUSED,  12'd4095, 12'd4095, 32'hFFFF_FFFF, CHK_NONE,  '0},
        '{OP_PRESS,   12'd4095, 12'd4095, 32'hFFFF_FFF0, CHK_NONE,  '0},
        '{OP_RELEASE, 12'd4095, 12'd4095, 32'h0000_0010, CHK_NONE,  '0},
        '{OP_PRESS,   12'd2048, 12'd2048, 32'hFFFF_FF00, CHK_NONE,  '0},
        '{OP_MOVE,    12'd2050, 12'd2049, 32'd1,         CHK_MODEL, '0},
        '{OP_MOVE,    12'd2050, 12'd2049, 32'd2,         CHK_MODEL, '0},
        '{OP_MOVE,    12'd2050, 12'd2060, 32'd3,         CHK_MODEL, '0},
        '{OP_RELEASE, 12'd2050, 12'd2060, 32'h0000_0010, CHK_MODEL, '0},
        '{OP_MOVE,    12'd2040, 12'd2060, 32'h0000_0020, CHK_MODEL, '0},
        '{OP_PRESS,   12'd0,    12'd4095, 32'd0,         CHK_NONE,  '0},
        '{OP_MOVE,    12'd0,    12'd0,    32'd1,         CHK_FIXED,
          '{-16'sd4095, 16'd0, DIR_UP, KIND_MOVE}},
        '{OP_RELEASE, 12'd4095, 12'd0,    32'd300,       CHK_FIXED,
          '{-16'sd4095, 16'd4095, DIR_UP, KIND_SLOW}},
        '{OP_PRESS,   12'd4095, 12'd0,    32'd5,         CHK_NONE,  '0},
        '{OP_MOVE,    12'd4089, 12'd0,    32'd6,         CHK_MODEL, '0},
        '{OP_MOVE,    12'd0,    12'd4095, 32'd7,         CHK_MODEL, '0},
        '{OP_RELEASE, 12'd0,    12'd4095, 32'd4,         CHK_MODEL, '0},
        '{OP_PRESS,   12'd100,  12'd100,  32'd1000,      CHK_NONE,  '0},
        '{OP_MOVE,    12'd105,  12'd100,  32'd1001,      CHK_MODEL, '0},
        '{OP_MOVE,    12'd100,  12'd106,  32'd1002,      CHK_MODEL, '0},
        '{OP_RELEASE, 12'd100,  12'd106,  32'd1299,      CHK_MODEL, '0},
        '{OP_PRESS,   12'd100,  12'd100,  32'd0,         CHK_NONE,  '0},
        '{OP_MOVE,    12'd110,  12'd110,  32'd1,         CHK_MODEL, '0},
        '{OP_MOVE,    12'd110,  12'd104,  32'd2,         CHK_MODEL, '0},
        '{OP_RELEASE, 12'd110,  12'd104,  32'hFFFF_FFFF, CHK_MODEL, '0}
    };

    function automatic bit classify_event(input logic [1:0] op, input logic [11:0] px,
                                          input logic [11:0] py, input logic [31:0] tk,
                                          output t_result res);
        int    dx;
        int    dy;
        int    ax;
        int    ay;
        int    thr;
        t_kind kind;
        res  = '0;
        kind = KIND_MOVE;
        thr  = int'(move_thr);
        dx   = int'(px) - int'(last_x);
        dy   = int'(py) - int'(last_y);
        ax   = (dx < 0) ? -dx : dx;
        ay   = (dy < 0) ? -dy : dy;
        case (op)
            OP_PRESS: begin
                last_x     = px;
                last_y     = py;
                press_tick = tk;
                lock       = LOCK_NONE;
                sign       = SIGN_UNKNOWN;
                acc_x      = '0;
                acc_y      = '0;
                return 1'b0;
            end
            OP_MOVE, OP_RELEASE: begin
                if (dx > 0) sign = SIGN_RIGHT;
                if (dx < 0) sign = SIGN_LEFT;
                acc_x = acc_x + 16'(dx);
                acc_y = acc_y + 16'(dy);
                if (op == OP_MOVE && lock == LOCK_NONE) begin
                    if (ax > ay && ax > thr) begin
                        lock = LOCK_HORIZ;
                    end else if (ay > ax) begin
                        if (dy > thr) lock = LOCK_DOWN;
                        if (dy < -thr) lock = LOCK_UP;
                    end
                end
                if (op == OP_RELEASE) begin
                    if ((tk - press_tick) < {16'd0, fast_ticks}) kind = KIND_FAST;
                    else kind = KIND_SLOW;
                end
                last_x = px;
                last_y = py;
            end
            default: return 1'b0;
        endcase
        if (lock == LOCK_NONE) return 1'b0;
        res.kind  = kind;
        res.off_x = acc_x;
        res.off_y = acc_y;
        if (lock == LOCK_HORIZ) begin
            if (sign == SIGN_RIGHT) res.dir = DIR_RIGHT;
            else res.dir = DIR_LEFT;
        end else if (lock == LOCK_DOWN) begin
            res.dir = DIR_DOWN;
        end else begin
            res.dir = DIR_UP;
        end
        return 1'b1;
    endfunction

    task automatic send_event(input logic [1:0] op, input logic [11:0] px,
                              input logic [11:0] py, input logic [31:0] tk,
                              input t_chk chk, input t_result fixed);
        int      gap;
        bit      has;
        t_result res;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(40, 120);
            else burst_left = $urandom_range(1, 12);
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, tk, py, px, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_items++;
        has = classify_event(op, px, py, tk, res);
        if (chk == CHK_FIXED) pending_swipes.push_back(fixed);
        else if (chk == CHK_MODEL && has) pending_swipes.push_back(res);
    endtask

    // hold input idle until every expected result is out, then let the pipeline settle
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_swipes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FAST_TIME) fast_ticks = val;
        else move_thr = val[THR_W-1:0];
    endtask

    function automatic int next_coord(input int c);
        int d;
        int lim;
        lim = int'(move_thr) + 2;
        case ($urandom_range(0, 3))
            0: d = 0;
            1: d = int'($urandom_range(0, 2 * lim)) - lim;
            2: d = ($urandom_range(0, 1) ? 1 : -1) * (int'(move_thr) + int'($urandom_range(0, 1)));
            default: d = int'($urandom_range(0, 2 * COORD_MAX)) - COORD_MAX;
        endcase
        c = c + d;
        if (c < 0) c = 0;
        if (c > COORD_MAX) c = COORD_MAX;
        return c;
    endfunction

    task automatic run_gestures(input int count);
        int          sent;
        int          cx;
        int          cy;
        int          n_steps;
        logic [31:0] t0;
        logic [31:0] elapsed;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_event(2'($urandom_range(0, 3)), 12'($urandom), 12'($urandom), $urandom,
                           CHK_MODEL, '0);
                sent++;
            end else begin
                cx = $urandom_range(0, COORD_MAX);
                cy = $urandom_range(0, COORD_MAX);
                t0 = $urandom;
                if ($urandom_range(0, 7) != 0) begin
                    send_event(OP_PRESS, 12'(cx), 12'(cy), t0, CHK_MODEL, '0);
                    sent++;
                end
                n_steps = $urandom_range(0, 8);
                repeat (n_steps) begin
                    cx = next_coord(cx);
                    cy = next_coord(cy);
                    send_event(OP_MOVE, 12'(cx), 12'(cy), $urandom, CHK_MODEL, '0);
                    sent++;
                end
                if ($urandom_range(0, 9) != 0) begin
                    case ($urandom_range(0, 3))
                        0: elapsed = {16'd0, fast_ticks} - 32'd1;
                        1: elapsed = {16'd0, fast_ticks};
                        2: elapsed = $urandom_range(0, 2 * int'(fast_ticks) + 2);
                        default: elapsed = $urandom;
                    endcase
                    cx = next_coord(cx);
                    cy = next_coord(cy);
                    send_event(OP_RELEASE, 12'(cx), 12'(cy), t0 + elapsed, CHK_MODEL, '0);
                    sent++;
                end
            end
            if ($urandom_range(0, 60) == 0) drain_pipeline();
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[35:0];
            if (pending_swipes.size() == 0) begin
                $display("%0t: expected no result, got %h", $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_swipes.pop_front();
                n_results++;
                case (want.kind)
                    KIND_FAST: n_fast++;
                    KIND_SLOW: n_slow++;
                    default: n_moves++;
                endcase
                if (got.kind !== want.kind) begin
                    $display("%0t: msg_kind expected %0d got %0d", $time, want.kind, got.kind);
                    mismatches++;
                end
                if (got.dir !== want.dir) begin
                    $display("%0t: direction expected %0d got %0d", $time, want.dir, got.dir);
                    mismatches++;
                end
                if (got.off_x !== want.off_x) begin
                    $display("%0t: disp_x expected %0d got %0d", $time,
                             $signed(want.off_x), $signed(got.off_x));
                    mismatches++;
                end
                if (got.off_y !== want.off_y) begin
                    $display("%0t: disp_y expected %0d got %0d", $time,
                             $signed(want.off_y), $signed(got.off_y));
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("touch_swipe_classifier_unit_tb: done, errors");
        $finish;
    end

    initial begin
        logic [FAST_W-1:0] fast_val;
        logic [THR_W-1:0]  thr_val;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (swipe_script[r]) begin
            send_event(swipe_script[r].op, swipe_script[r].px, swipe_script[r].py,
                       swipe_script[r].tk, swipe_script[r].chk, swipe_script[r].res);
        end
        drain_pipeline();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin fast_val = 16'hFFFF; thr_val = 8'hFF; end
                1: begin fast_val = 16'd0;    thr_val = 8'd0;   end
                2: begin fast_val = 16'd1;    thr_val = 8'd1;   end
                3: begin
                    fast_val = 16'($urandom_range(0, 700));
                    thr_val  = 8'($urandom_range(0, 20));
                end
                4: begin
                    fast_val = 16'($urandom);
                    thr_val  = 8'($urandom);
                end
                default: begin fast_val = FAST_TIME_RESET; thr_val = MOVE_THR_RESET; end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(REG_MOVE_THR, {8'($urandom), thr_val});
                write_reg(REG_FAST_TIME, fast_val);
            end else begin
                write_reg(REG_FAST_TIME, fast_val);
                write_reg(REG_MOVE_THR, {8'($urandom), thr_val});
            end
            n_settings++;
            run_gestures(250);
            drain_pipeline();
        end

        $display("covered %0d events under %0d register settings", n_items, n_settings);
        $display("checked %0d results: %0d moves, %0d fast and %0d slow releases",
                 n_results, n_moves, n_fast, n_slow);
        if (mismatches == 0) begin
            $display("touch_swipe_classifier_unit_tb: done, clean");
        end else begin
            $display("touch_swipe_classifier_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

/* touch_swipe_classifier_unit.f */
rtl/core/tsc_pkg.sv
rtl/core/tsc_step.sv
rtl/core/touch_swipe_classifier_unit.sv
rtl/core/tsc_checker.sv
tb/sv/touch_swipe_classifier_unit_tb.sv
